/* sv/mrgg_pkg.sv */
// ----------------------------------------------------------------------------
// mrgg_pkg
// Shared types, constants and the sigmoid table of the rhythm gate generator.
// ----------------------------------------------------------------------------
package mrgg_pkg;

    localparam int HIST_DEPTH      = 16;
    localparam int HIST_AW         = $clog2(HIST_DEPTH);
    localparam int SEL_W           = HIST_AW + 1;
    localparam int LOGIT_TABLE_SIZE = 257;
    localparam int ROM_AW          = $clog2(LOGIT_TABLE_SIZE);

    localparam int DATA_W   = 16;
    localparam int LOOP_W   = 5;
    localparam int STREAK_W = 5;
    localparam int B_W      = 18;
    localparam int AB_W     = 17;
    localparam int SQ_W     = 34;
    localparam int PQ_W     = 38;
    localparam int LOGIT_W  = 40;
    localparam int Q_W      = 11;
    localparam int PROD_W   = 22;
    localparam int DIV5_SH  = 13;

    localparam logic [STREAK_W-1:0] STREAK_MAX     = '1;
    localparam logic [STREAK_W-1:0] STREAK_BONUS_AT = STREAK_W'(24);

    localparam logic signed [LOGIT_W-1:0] LOGIT_ONE  = LOGIT_W'(64'sd1 <<< 34);
    localparam logic signed [LOGIT_W-1:0] LOGIT_BASE = -(LOGIT_ONE + (LOGIT_ONE >>> 1));
    localparam logic signed [LOGIT_W-1:0] LOGIT_LIM  = LOGIT_W'(64'sd10 <<< 34);
    localparam int                        LOGIT_SH   = 28;
    localparam logic signed [LOGIT_W-1:0] IDX_OFFSET = LOGIT_W'(640);
    localparam logic [PROD_W-1:0]         DIV5_RECIP = PROD_W'(1639);

    localparam logic [DATA_W-1:0]  BIAS_RESET = DATA_W'(32768);
    localparam logic [LOOP_W-1:0]  LOOP_RESET = LOOP_W'(8);
    localparam logic signed [B_W-1:0]  B_RESET  = B_W'(32768);
    localparam logic signed [PQ_W-1:0] PQ_RESET = PQ_W'(64'sd1 <<< 33);

    localparam logic [63:0] EXP_STEP_Q32 = 64'd3972195407;

    typedef enum logic [1:0] {
        CFG_BIAS    = 2'd0,
        CFG_DEJA_VU = 2'd1,
        CFG_LOOP    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic periodic;
        logic simultaneous;
        logic dense;
        logic alternate;
        logic replay;
        logic replay_bit;
    } t_ch_flags;

    typedef logic [DATA_W-1:0] t_sig_rom [LOGIT_TABLE_SIZE];

    function automatic t_sig_rom build_sigmoid();
        t_sig_rom    rom;
        logic [63:0] r;
        logic [63:0] d;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] quo;
        int          m;
        int          a;
        for (int k = 0; k < LOGIT_TABLE_SIZE; k++) begin
            m = k - (LOGIT_TABLE_SIZE - 1) / 2;
            a = (m < 0) ? -m : m;
            r = 64'd1 << 32;
            for (int i = 0; i < a; i++) begin
                r = (r * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
            end
            d   = (64'd1 << 32) + r;
            num = (64'd1 << 48) + (d >> 1);
            rem = '0;
            quo = '0;
            for (int i = 49; i >= 0; i--) begin
                rem = {rem[62:0], num[i]};
                if (rem >= d) begin
                    rem    = rem - d;
                    quo[i] = 1'b1;
                end
            end
            if (m < 0) begin
                quo = 64'd65536 - quo;
            end
            rom[k] = quo[DATA_W-1:0];
        end
        return rom;
    endfunction

    localparam t_sig_rom SIGMOID_ROM = build_sigmoid();

endpackage

/* sv/mrgg_channel.sv */
// ----------------------------------------------------------------------------
// mrgg_channel
// Per-channel logit sum, clamp, sigmoid lookup and fire decision.
// ----------------------------------------------------------------------------
module mrgg_channel
    import mrgg_pkg::*;
(
    input  t_ch_flags                 i_flags,
    input  logic [STREAK_W-1:0]       i_streak,
    input  logic [DATA_W-1:0]         i_rnd,
    input  logic signed [B_W-1:0]     i_b,
    input  logic signed [PQ_W-1:0]    i_pq,
    output logic                      o_fire
);

    logic signed [LOGIT_W-1:0] w_pq;
    logic signed [LOGIT_W-1:0] w_b18;
    logic signed [LOGIT_W-1:0] w_b17;
    logic signed [LOGIT_W-1:0] w_logit;
    logic signed [LOGIT_W-1:0] w_clamp;
    logic signed [LOGIT_W-1:0] w_shift;
    logic [Q_W-1:0]            w_q;
    logic [PROD_W-1:0]         w_prod;
    logic [ROM_AW-1:0]         w_idx;
    logic [DATA_W-1:0]         w_prob;

    always_comb begin
        w_pq  = LOGIT_W'(i_pq);
        w_b18 = LOGIT_W'(i_b) <<< 18;
        w_b17 = LOGIT_W'(i_b) <<< 17;

        w_logit = LOGIT_BASE;
        if (i_streak > STREAK_BONUS_AT) begin
            w_logit = w_logit + LOGIT_LIM;
        end
        w_logit = i_flags.periodic     ? w_logit + w_pq  : w_logit - w_pq;
        w_logit = i_flags.simultaneous ? w_logit - w_b18 : w_logit + w_b18;
        if (i_flags.dense) begin
            w_logit = w_logit - w_b17;
        end
        if (i_flags.alternate) begin
            w_logit = w_logit + w_b17;
        end

        if (w_logit > LOGIT_LIM) begin
            w_clamp = LOGIT_LIM;
        end else if (w_logit < -LOGIT_LIM) begin
            w_clamp = -LOGIT_LIM;
        end else begin
            w_clamp = w_logit;
        end

        // floor(12.8 * L + 128) as floor(q / 5)
        w_shift = (w_clamp >>> LOGIT_SH) + IDX_OFFSET;
        w_q     = w_shift[Q_W-1:0];
        w_prod  = PROD_W'(w_q) * DIV5_RECIP;
        w_idx   = w_prod[DIV5_SH +: ROM_AW];
        w_prob  = SIGMOID_ROM[w_idx];

        o_fire = i_flags.replay ? i_flags.replay_bit : (i_rnd < w_prob);
    end

endmodule

/* sv/markov_rhythm_gate_generator_unit.sv */
// ----------------------------------------------------------------------------
// markov_rhythm_gate_generator_unit
// Two-channel Markov rhythm gate generator with history replay.
// ----------------------------------------------------------------------------
// One tick word is taken per clock while the output is not stalled. A word
// sits in an input register while the logit sum, sigmoid table lookup and
// history update run, and its gate word then moves from the input register
// into the output register, which raises output valid: throughput one word
// per cycle when not stalled, set by the combinational path from the history
// taps through the logit adder and the 257-entry sigmoid table. A full output
// register that is not taken stalls the input register, which drops ready. Bias
// writes are squared on the write itself, so the products are ready with the
// register. Past gate words live in a shift line of HIST_DEPTH - 1 entries;
// a replay distance of zero or HIST_DEPTH reads the current, empty slot.
module markov_rhythm_gate_generator_unit
    import mrgg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [DATA_W-1:0] i_rand_ch0,
    input  logic [DATA_W-1:0] i_rand_ch1,
    input  logic [DATA_W-1:0] i_replay_draw,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_gate_bits,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [DATA_W-1:0] i_cfg_data
);

    logic signed [B_W-1:0]  r_b;
    logic signed [PQ_W-1:0] r_pq;
    logic [DATA_W-1:0]      r_dv;
    logic [LOOP_W-1:0]      r_loop;

    logic                   r_in_valid;
    logic [DATA_W-1:0]      r_rnd0;
    logic [DATA_W-1:0]      r_rnd1;
    logic [DATA_W-1:0]      r_draw;

    logic                   r_out_valid;
    logic [1:0]             r_gates;

    logic [1:0]             r_hist [1:HIST_DEPTH-1];
    logic [STREAK_W-1:0]    r_streak0;
    logic [STREAK_W-1:0]    r_streak1;

    logic signed [B_W-1:0]  w_cfg_b;
    logic [AB_W-1:0]        w_cfg_ab;
    logic [SQ_W-1:0]        w_cfg_sq;
    logic [PQ_W-1:0]        w_cfg_sq8;
    logic signed [PQ_W-1:0] w_cfg_pq;

    logic                   w_out_free;
    logic                   w_adv;
    logic                   w_replay;
    logic [SEL_W-1:0]       w_loop_ext;
    logic [SEL_W-1:0]       w_wrap;
    logic [HIST_AW-1:0]     w_sel;
    logic [1:0]             w_hsel;
    t_ch_flags              w_flags0;
    t_ch_flags              w_flags1;
    logic                   w_fire0;
    logic                   w_fire1;
    logic [1:0]             w_gates;

    // config products
    always_comb begin
        w_cfg_b   = B_W'(19'(i_cfg_data) * 19'd3 - 19'd65536);
        w_cfg_ab  = w_cfg_b[B_W-1] ? AB_W'(-w_cfg_b) : w_cfg_b[AB_W-1:0];
        w_cfg_sq  = SQ_W'(w_cfg_ab) * SQ_W'(w_cfg_ab);
        w_cfg_sq8 = {1'b0, w_cfg_sq, 3'b000};
        w_cfg_pq  = w_cfg_b[B_W-1] ? -$signed(w_cfg_sq8) : $signed(w_cfg_sq8);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b    <= B_RESET;
            r_pq   <= PQ_RESET;
            r_dv   <= '0;
            r_loop <= LOOP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BIAS: begin
                    r_b  <= w_cfg_b;
                    r_pq <= w_cfg_pq;
                end
                CFG_DEJA_VU: begin
                    r_dv <= i_cfg_data;
                end
                CFG_LOOP: begin
                    r_loop <= i_cfg_data[LOOP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // handshake
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_adv       = r_in_valid && w_out_free;
    assign o_in_ready  = !r_in_valid || w_out_free;
    assign o_out_valid = r_out_valid;
    assign o_gate_bits = r_gates;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_rnd0 <= i_rand_ch0;
            r_rnd1 <= i_rand_ch1;
            r_draw <= i_replay_draw;
        end
    end

    // replay tap
    always_comb begin
        w_replay   = r_dv >= r_draw;
        w_loop_ext = SEL_W'(r_loop);
        w_wrap     = (w_loop_ext >= SEL_W'(HIST_DEPTH)) ?
                     w_loop_ext - SEL_W'(HIST_DEPTH) : w_loop_ext;
        w_sel      = w_wrap[HIST_AW-1:0];
        w_hsel     = (w_sel == '0) ? 2'b00 : r_hist[w_sel];

        w_flags0.periodic     = r_hist[8][0];
        w_flags0.simultaneous = r_hist[8][1];
        w_flags0.dense        = r_hist[1][0];
        w_flags0.alternate    = r_hist[4][1];
        w_flags0.replay       = w_replay;
        w_flags0.replay_bit   = w_hsel[0];

        w_flags1.periodic     = r_hist[8][1];
        w_flags1.simultaneous = r_hist[8][0];
        w_flags1.dense        = r_hist[1][1];
        w_flags1.alternate    = r_hist[4][0];
        w_flags1.replay       = w_replay;
        w_flags1.replay_bit   = w_hsel[1];
    end

    mrgg_channel u_ch0 (
        .i_flags  (w_flags0),
        .i_streak (r_streak0),
        .i_rnd    (r_rnd0),
        .i_b      (r_b),
        .i_pq     (r_pq),
        .o_fire   (w_fire0)
    );

    mrgg_channel u_ch1 (
        .i_flags  (w_flags1),
        .i_streak (r_streak1),
        .i_rnd    (r_rnd1),
        .i_b      (r_b),
        .i_pq     (r_pq),
        .o_fire   (w_fire1)
    );

    assign w_gates = {w_fire1, w_fire0};

    // advance state and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_streak0   <= '0;
            r_streak1   <= '0;
            for (int k = 1; k < HIST_DEPTH; k++) begin
                r_hist[k] <= '0;
            end
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
            r_hist[1]   <= w_gates;
            for (int k = 2; k < HIST_DEPTH; k++) begin
                r_hist[k] <= r_hist[k-1];
            end
            if (w_fire0) begin
                r_streak0 <= '0;
            end else if (r_streak0 != STREAK_MAX) begin
                r_streak0 <= r_streak0 + 1'b1;
            end
            if (w_fire1) begin
                r_streak1 <= '0;
            end else if (r_streak1 != STREAK_MAX) begin
                r_streak1 <= r_streak1 + 1'b1;
            end
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_gates <= w_gates;
        end
    end

`ifndef SYNTHESIS
    a_hist_tracks_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_hist[1] == r_gates)
        else $error("history head differs from delivered word");

    a_streak_clear0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && w_fire0 |=> r_streak0 == '0)
        else $error("streak 0 not cleared on fire");

    a_streak_clear1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && w_fire1 |=> r_streak1 == '0)
        else $error("streak 1 not cleared on fire");

    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while pipe is stalled");

    a_replay_zero_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && w_replay && w_sel == '0 |=> r_gates == 2'b00)
        else $error("replay of current slot produced a gate");
`endif

endmodule
